>>> rtl/core/symbol_histogram_min_extract_macros.svh
// ----------------------------------------------------------------------------
// Symbol histogram assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_HISTOGRAM_MIN_EXTRACT_MACROS_SVH
`define SYMBOL_HISTOGRAM_MIN_EXTRACT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("symbol histogram assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SHM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("symbol histogram assertion failed");

`endif

>>> rtl/core/shm_pkg.sv
// ----------------------------------------------------------------------------
// Symbol histogram package
// Shared constants, state encoding and memory control type.
// ----------------------------------------------------------------------------
package shm_pkg;

  // Default sizing of the frequency table.
  localparam int unsigned SymbolsDef    = 256;
  localparam int unsigned CountWidthDef = 32;

  // Fixed field widths of the stream payloads.
  localparam int unsigned SymW      = 8;
  localparam int unsigned OutCountW = 32;
  localparam int unsigned EntryW    = 9;

  // Input transaction kinds carried in tuser.
  localparam logic ModeCount   = 1'b0;
  localparam logic ModeExtract = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle,
    StWrite,
    StScan,
    StFinish
  } shm_state_e;

  // Memory port strobes from the controller.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } mem_ctl_t;

endpackage

>>> rtl/core/shm_count_mem.sv
// ----------------------------------------------------------------------------
// Symbol count memory
// One-read, one-write synchronous count store with per-entry valid flags.
// ----------------------------------------------------------------------------
module shm_count_mem
  import shm_pkg::*;
#(
  parameter int unsigned Symbols    = SymbolsDef,
  parameter int unsigned CountWidth = CountWidthDef,
  localparam int unsigned AddrW     = $clog2(Symbols)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mem_ctl_t              ctl_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  logic [CountWidth-1:0] wr_data_i,
  input  logic [AddrW-1:0]      clr_addr_i,
  output logic [CountWidth-1:0] rd_data_o,
  output logic                  rd_valid_o
);

  logic [CountWidth-1:0] mem_q [Symbols];
  logic [CountWidth-1:0] rd_data_q;
  logic [Symbols-1:0]    valid_q;
  logic                  rd_valid_q;

  // Count array: registered read, single write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Valid flags: an entry not written since reset or since its last clear reads as invalid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.clr_en) begin
        valid_q[clr_addr_i] <= 1'b0;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

>>> rtl/core/shm_ctrl.sv
// ----------------------------------------------------------------------------
// Symbol histogram controller
// Sequences count updates and the minimum scan over the count memory.
// ----------------------------------------------------------------------------
module shm_ctrl
  import shm_pkg::*;
#(
  parameter int unsigned Symbols    = SymbolsDef,
  parameter int unsigned CountWidth = CountWidthDef,
  localparam int unsigned AddrW     = $clog2(Symbols)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_mode_i,
  input  logic [SymW-1:0]       in_symbol_i,
  // Result stream
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SymW-1:0]       out_symbol_o,
  output logic [OutCountW-1:0]  out_count_o,
  output logic                  out_empty_o,
  output logic [EntryW-1:0]     out_left_o,
  // Memory port
  output mem_ctl_t              mem_ctl_o,
  output logic [AddrW-1:0]      rd_addr_o,
  output logic [AddrW-1:0]      wr_addr_o,
  output logic [CountWidth-1:0] wr_data_o,
  output logic [AddrW-1:0]      clr_addr_o,
  input  logic [CountWidth-1:0] rd_data_i,
  input  logic                  rd_valid_i
);

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [AddrW:0]        ScanEnd  = (AddrW+1)'(Symbols);

  shm_state_e state_q, state_d;

  logic [AddrW-1:0]      sym_q, sym_d;
  logic                  op_ok_q, op_ok_d;
  logic [AddrW:0]        scan_q, scan_d;
  logic [AddrW-1:0]      cur_q, cur_d;
  logic                  found_q, found_d;
  logic [AddrW-1:0]      best_sym_q, best_sym_d;
  logic [CountWidth-1:0] best_cnt_q, best_cnt_d;
  logic [EntryW-1:0]     total_q, total_d;

  logic                  out_valid_q, out_valid_d;
  logic [SymW-1:0]       out_sym_q, out_sym_d;
  logic [OutCountW-1:0]  out_cnt_q, out_cnt_d;
  logic                  out_empty_q, out_empty_d;
  logic [EntryW-1:0]     out_left_q, out_left_d;

  logic                  sym_legal;
  logic [CountWidth-1:0] new_cnt;
  logic                  take;
  logic                  out_free;
  logic [63:0]           cnt_wide;

  // Symbol zero and symbols past the table are dropped.
  assign sym_legal = (in_symbol_i != '0) && (EntryW'(in_symbol_i) < EntryW'(Symbols));

  // Saturating increment; an absent entry starts at one.
  assign new_cnt = !rd_valid_i ? CountWidth'(1) :
                   ((rd_data_i == CountMax) ? rd_data_i : rd_data_i + CountWidth'(1));

  // Strict less-than keeps the lowest symbol among equal counts.
  assign take = rd_valid_i && (!found_q || (rd_data_i < best_cnt_q));

  assign out_free = !out_valid_q || out_ready_i;
  assign cnt_wide = 64'(best_cnt_q);

  // Control and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    op_ok_q     <= op_ok_d;
    scan_q      <= scan_d;
    cur_q       <= cur_d;
    found_q     <= found_d;
    best_sym_q  <= best_sym_d;
    best_cnt_q  <= best_cnt_d;
    out_sym_q   <= out_sym_d;
    out_cnt_q   <= out_cnt_d;
    out_empty_q <= out_empty_d;
    out_left_q  <= out_left_d;
  end

  // Next state, memory strobes and result loading.
  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    op_ok_d     = op_ok_q;
    scan_d      = scan_q;
    cur_d       = cur_q;
    found_d     = found_q;
    best_sym_d  = best_sym_q;
    best_cnt_d  = best_cnt_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_cnt_d   = out_cnt_q;
    out_empty_d = out_empty_q;
    out_left_d  = out_left_q;
    mem_ctl_o   = '0;
    rd_addr_o   = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == ModeCount) begin
            sym_d           = in_symbol_i[AddrW-1:0];
            op_ok_d         = sym_legal;
            mem_ctl_o.rd_en = sym_legal;
            rd_addr_o       = in_symbol_i[AddrW-1:0];
            state_d         = StWrite;
          end else begin
            mem_ctl_o.rd_en = 1'b1;
            rd_addr_o       = '0;
            cur_d           = '0;
            scan_d          = (AddrW+1)'(1);
            found_d         = 1'b0;
            state_d         = StScan;
          end
        end
      end
      StWrite: begin
        if (op_ok_q) begin
          mem_ctl_o.wr_en = 1'b1;
          if (!rd_valid_i) begin
            total_d = total_q + EntryW'(1);
          end
        end
        state_d = StIdle;
      end
      StScan: begin
        if (take) begin
          found_d    = 1'b1;
          best_sym_d = cur_q;
          best_cnt_d = rd_data_i;
        end
        if (scan_q == ScanEnd) begin
          state_d = StFinish;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          rd_addr_o       = scan_q[AddrW-1:0];
          cur_d           = scan_q[AddrW-1:0];
          scan_d          = scan_q + (AddrW+1)'(1);
        end
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (found_q) begin
            mem_ctl_o.clr_en = 1'b1;
            total_d          = total_q - EntryW'(1);
            out_sym_d        = SymW'(best_sym_q);
            out_cnt_d        = cnt_wide[OutCountW-1:0];
            out_empty_d      = 1'b0;
            out_left_d       = total_q - EntryW'(1);
          end else begin
            out_sym_d   = '0;
            out_cnt_d   = '0;
            out_empty_d = 1'b1;
            out_left_d  = '0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign wr_addr_o    = sym_q;
  assign wr_data_o    = new_cnt;
  assign clr_addr_o   = best_sym_q;
  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign out_count_o  = out_cnt_q;
  assign out_empty_o  = out_empty_q;
  assign out_left_o   = out_left_q;

endmodule

>>> rtl/core/symbol_histogram_min_extract.sv
// ----------------------------------------------------------------------------
// Symbol histogram with minimum extraction
// Byte frequency table served as a min-priority queue for Huffman coding.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one transaction at a time. tuser selects the kind:
//   a count transaction adds one to the count of the symbol in tdata, and an
//   extract transaction removes the least-count symbol (lowest symbol on ties).
//   Only extract transactions produce a result on the master stream.
//   A count transaction occupies the block for one memory read and
//   one write-back of the same entry.
//   An extract transaction scans the table, reading one memory entry per
//   cycle through the single read port, and then loads the result register.
//   The result sits in an output register; the next transaction is accepted
//   while it waits. If a second extract finishes while the receiver still
//   stalls, it holds until the output register frees up.
//   Reset clears all counts at once through per-entry valid flags, so the
//   block accepts transactions in the first cycle after reset.
// ----------------------------------------------------------------------------
module symbol_histogram_min_extract
  import shm_pkg::*;
#(
  parameter int unsigned SYMBOLS     = SymbolsDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tuser_i,   // [0] mode
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [7:0] out_symbol, [39:8] out_count,
                                        // [48:40] entries_left, [55:49] zero
  output logic        m_axis_tuser_o    // [0] was_empty
);

  localparam int unsigned AddrW = $clog2(SYMBOLS);

  mem_ctl_t               mem_ctl;
  logic [AddrW-1:0]       rd_addr;
  logic [AddrW-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [AddrW-1:0]       clr_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_valid;
  logic [SymW-1:0]        out_symbol;
  logic [OutCountW-1:0]   out_count;
  logic [EntryW-1:0]      entries_left;

  // Sequencer for count and extract transactions.
  shm_ctrl #(
    .Symbols    (SYMBOLS),
    .CountWidth (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_mode_i    (s_axis_tuser_i),
    .in_symbol_i  (s_axis_tdata_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_symbol_o (out_symbol),
    .out_count_o  (out_count),
    .out_empty_o  (m_axis_tuser_o),
    .out_left_o   (entries_left),
    .mem_ctl_o    (mem_ctl),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .clr_addr_o   (clr_addr),
    .rd_data_i    (rd_data),
    .rd_valid_i   (rd_valid)
  );

  // Count store.
  shm_count_mem #(
    .Symbols    (SYMBOLS),
    .CountWidth (COUNT_WIDTH)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mem_ctl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .clr_addr_i (clr_addr),
    .rd_data_o  (rd_data),
    .rd_valid_o (rd_valid)
  );

  // Result packing, lowest field first.
  assign m_axis_tdata_o = {7'b0, entries_left, out_count, out_symbol};

endmodule

>>> rtl/core/shm_checker.sv
// ----------------------------------------------------------------------------
// Symbol histogram port checker
// Port-level assertions on the stream behavior of the histogram block.
// ----------------------------------------------------------------------------
`include "symbol_histogram_min_extract_macros.svh"

module shm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // A stalled result keeps its payload.
  `SHM_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // An empty extract reports all-zero fields.
  `SHM_ASSERT_NOW(a_empty_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == 56'd0)

  // Symbol zero is never held, so at most 254 entries remain after a removal.
  `SHM_ASSERT_NOW(a_left_range, m_axis_tvalid_o, m_axis_tdata_o[48] == 1'b0)

  // The block never accepts transactions back to back.
  `SHM_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

endmodule

bind symbol_histogram_min_extract shm_checker u_shm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> test/symbol_histogram_min_extract_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Symbol histogram checker
// Watches both streams of the histogram block, keeps its own frequency table
// and compares every extract result with the predicted minimum entry.
// ----------------------------------------------------------------------------
module symbol_histogram_min_extract_checker
  import shm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream as seen on the block's slave side
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tuser_i,   // [0] mode
  // Result stream as seen on the block's master side
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [55:0] m_axis_tdata_i,   // [7:0] out_symbol, [39:8] out_count,
                                        // [48:40] entries_left, [55:49] zero
  input  logic        m_axis_tuser_i,   // [0] was_empty
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);

  // One predicted extract result.
  typedef struct packed {
    logic [SymW-1:0]      sym;
    logic [OutCountW-1:0] cnt;
    logic [EntryW-1:0]    left;
    logic                 empty;
  } min_result_t;

  // Predicted frequency table and number of symbols held.
  logic [OutCountW-1:0] freq_tbl [0:255];
  logic [EntryW-1:0]    held_total;
  min_result_t          expected_mins [$];

  // Add one occurrence of a symbol; symbol zero is the string end mark.
  task automatic tally_symbol(input logic [SymW-1:0] sym);
    if (sym != '0) begin
      if (freq_tbl[sym] == '0) begin
        freq_tbl[sym] = 1;
        held_total    = held_total + 1'b1;
      end else if (freq_tbl[sym] != '1) begin
        freq_tbl[sym] = freq_tbl[sym] + 1'b1;
      end
    end
  endtask

  // Remove the lowest symbol that holds the least nonzero count.
  task automatic pop_least_frequent(output min_result_t res);
    int best;
    best = -1;
    for (int s = 0; s < 256; s++) begin
      if (freq_tbl[s] != '0 && (best < 0 || freq_tbl[s] < freq_tbl[best])) begin
        best = s;
      end
    end
    if (best < 0) begin
      res.sym   = '0;
      res.cnt   = '0;
      res.left  = '0;
      res.empty = 1'b1;
    end else begin
      res.sym        = best[SymW-1:0];
      res.cnt        = freq_tbl[best];
      freq_tbl[best] = '0;
      if (held_total != '0) begin
        held_total = held_total - 1'b1;
      end
      res.left  = held_total;
      res.empty = 1'b0;
    end
  endtask

  // Predict on each accepted input transaction and check each result.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    min_result_t want;
    min_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < 256; i++) begin
        freq_tbl[i] = '0;
      end
      held_total = '0;
      expected_mins.delete();
      mismatch_count_o = 0;
      outstanding_o    = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == ModeExtract) begin
          pop_least_frequent(want);
          expected_mins.push_back(want);
        end else begin
          tally_symbol(s_axis_tdata_i);
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.sym   = m_axis_tdata_i[SymW-1:0];
        got.cnt   = m_axis_tdata_i[SymW +: OutCountW];
        got.left  = m_axis_tdata_i[SymW+OutCountW +: EntryW];
        got.empty = m_axis_tuser_i;
        if (expected_mins.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("unexpected result: symbol %0d count %0d left %0d empty %0b",
                     got.sym, got.cnt, got.left, got.empty);
          end
        end else begin
          want = expected_mins.pop_front();
          if (got.sym != want.sym || got.cnt != want.cnt ||
              got.left != want.left || got.empty != want.empty) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("mismatch: expected symbol %0d count %0d left %0d empty %0b",
                       want.sym, want.cnt, want.left, want.empty);
              $display("          got      symbol %0d count %0d left %0d empty %0b",
                       got.sym, got.cnt, got.left, got.empty);
            end
          end
        end
      end
      outstanding_o = expected_mins.size();
    end
  end

endmodule

>>> test/symbol_histogram_min_extract_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Symbol histogram testbench
// Drives count and extract transactions with random stalls on both streams;
// the checker predicts every extract result and counts mismatches.
// ----------------------------------------------------------------------------
module symbol_histogram_min_extract_tb;
  import shm_pkg::*;

  localparam int unsigned CycleLimit = 5000000;
  localparam int unsigned DrainWait  = 600;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] symbol
  logic        s_axis_tuser_i;   // [0] mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [55:0] m_axis_tdata_o;   // [7:0] out_symbol, [39:8] out_count,
                                 // [48:40] entries_left, [55:49] zero
  logic        m_axis_tuser_o;   // [0] was_empty

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  symbol_histogram_min_extract u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  symbol_histogram_min_extract_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tuser_i   (s_axis_tuser_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .m_axis_tuser_i   (m_axis_tuser_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver stalls at random according to the current phase.
  initial m_axis_tready_i = 1'b0;
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Give up on a hung run.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("symbol_histogram_min_extract regression: fail");
      $finish;
    end
  end

  // Send one transaction; called and returning at a falling edge.
  task automatic send_txn(input logic mode, input logic [7:0] sym);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= sym;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly counts, many over a narrow pool to build ties and larger counts, with
  // extracts, terminator symbols and short drain bursts mixed in.
  task automatic run_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 11) begin
        send_txn(ModeExtract, 8'($urandom));
      end else if (r == 11) begin
        repeat (8) send_txn(ModeExtract, 8'($urandom));
      end else if (r < 14) begin
        send_txn(ModeCount, 8'd0);
      end else if (r < 60) begin
        send_txn(ModeCount, 8'($urandom_range(12, 1)));
      end else begin
        send_txn(ModeCount, 8'($urandom_range(255, 1)));
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = ModeCount;
    tx_idle_pct     = 33;
    rx_idle_pct     = 74;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table, terminator symbol, ties broken by the lowest symbol.
    send_txn(ModeExtract, 8'h00);
    send_txn(ModeCount,   8'd0);
    send_txn(ModeExtract, 8'hFF);
    send_txn(ModeCount,   8'd255);
    send_txn(ModeCount,   8'd1);
    send_txn(ModeCount,   8'd128);
    send_txn(ModeCount,   8'd1);
    send_txn(ModeExtract, 8'h00);
    send_txn(ModeCount,   8'd127);
    send_txn(ModeCount,   8'd127);
    send_txn(ModeCount,   8'd127);
    send_txn(ModeExtract, 8'h00);
    send_txn(ModeExtract, 8'h00);
    send_txn(ModeExtract, 8'h00);
    send_txn(ModeExtract, 8'h00);
    send_txn(ModeCount,   8'd85);
    send_txn(ModeCount,   8'd170);
    send_txn(ModeCount,   8'd85);
    send_txn(ModeCount,   8'd170);
    send_txn(ModeExtract, 8'h00);
    send_txn(ModeExtract, 8'h00);
    send_txn(ModeExtract, 8'h00);

    // Random traffic under three stall patterns.
    run_random(400);
    tx_idle_pct = 74;
    rx_idle_pct = 33;
    run_random(400);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(400);

    // Fill every symbol, then drain the table past empty.
    for (int s = 1; s < 256; s++) begin
      send_txn(ModeCount, 8'(s));
    end
    repeat (260) send_txn(ModeExtract, 8'($urandom));
    s_axis_tvalid_i <= 1'b0;

    // Let every expected result arrive, then allow for trailing activity.
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("symbol_histogram_min_extract regression: pass");
    end else begin
      $display("symbol_histogram_min_extract regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/shm_pkg.sv
rtl/core/shm_count_mem.sv
rtl/core/shm_ctrl.sv
rtl/core/symbol_histogram_min_extract.sv
rtl/core/shm_checker.sv
test/symbol_histogram_min_extract_checker.sv
test/symbol_histogram_min_extract_tb.sv
